// ===== rtl/plil_pkg.sv =====
// Shared constants and types for the piecewise linear interpolator.
package plil_pkg;

    // Fixed field widths of the stream items.
    localparam int DATA_W   = 32;
    localparam int CFG_W    = 7;
    localparam int IDX_W    = 7;

    // Quotient width: 32 integer bits of the depth offset plus 16 fraction bits.
    localparam int QUO_W    = 48;

    // The breakpoint search encodes hits in groups of this size.
    localparam int GRP_SIZE = 8;
    localparam int GRP_W    = 3;

    // Item kinds carried on the input tuser.
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Result status codes carried on the output tuser.
    localparam logic [1:0] ST_INTERP = 2'd0;
    localparam logic [1:0] ST_ZERO   = 2'd1;
    localparam logic [1:0] ST_EXTRA  = 2'd2;
    localparam logic [1:0] ST_SAT    = 2'd3;

    // Per-query data that rides alongside the divider and the multiplier.
    typedef struct packed {
        logic                     neg;
        logic                     zero;
        logic                     extra;
        logic [DATA_W-1:0]        adt;
        logic signed [DATA_W-1:0] t0;
    } t_side;

endpackage

// ===== rtl/plil_ram.sv =====
// Generic RAM with one write port and two registered read ports.
module plil_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 65,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_wa,
    input  logic [W-1:0]  i_wd,
    input  logic          i_re,
    input  logic [AW-1:0] i_ra0,
    input  logic [AW-1:0] i_ra1,
    output logic [W-1:0]  o_rd0,
    output logic [W-1:0]  o_rd1
);

    logic [W-1:0] r_mem [DEPTH];

    // Write, and read the old contents on a same-cycle collision.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        if (i_re) begin
            o_rd0 <= r_mem[i_ra0];
            o_rd1 <= r_mem[i_ra1];
        end
    end

endmodule

// ===== rtl/plil_search.sv =====
// Breakpoint search: parallel depth compares and a registered priority tree.
module plil_search #(
    parameter int MAX_POINTS = 64,
    localparam int IW        = $clog2(MAX_POINTS + 1),
    localparam int NG        = (MAX_POINTS + plil_pkg::GRP_SIZE - 1) / plil_pkg::GRP_SIZE
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_wr_en,
    input  logic [IW-1:0]                      i_wr_idx,
    input  logic signed [plil_pkg::DATA_W-1:0] i_wr_depth,
    input  logic                               i_q_valid,
    input  logic signed [plil_pkg::DATA_W-1:0] i_q,
    input  logic [IW-1:0]                      i_n,
    output logic                               o_valid,
    output logic [IW-1:0]                      o_seg,
    output logic signed [plil_pkg::DATA_W-1:0] o_q,
    output logic                               o_busy
);

    localparam int NB = NG * plil_pkg::GRP_SIZE;

    logic signed [plil_pkg::DATA_W-1:0] r_depth [1:MAX_POINTS-1];
    logic [NB-1:0]                      hit;

    logic                               r_a_valid;
    logic [NB-1:0]                      r_a_hit;
    logic signed [plil_pkg::DATA_W-1:0] r_a_q;
    logic [IW-1:0]                      r_a_n;

    logic [NG-1:0]                      n_b_any;
    logic [plil_pkg::GRP_W-1:0]         n_b_low [NG];
    logic                               r_b_valid;
    logic [NG-1:0]                      r_b_any;
    logic [plil_pkg::GRP_W-1:0]         r_b_low [NG];
    logic signed [plil_pkg::DATA_W-1:0] r_b_q;
    logic [IW-1:0]                      r_b_n;

    logic [IW-1:0]                      idx;
    logic [IW-1:0]                      n_c_seg;
    logic                               r_c_valid;
    logic [IW-1:0]                      r_c_seg;
    logic signed [plil_pkg::DATA_W-1:0] r_c_q;

    // Depth copies of the entries that take part in the search.
    always_ff @(posedge i_clk) begin
        for (int k = 1; k < MAX_POINTS; k++) begin
            if (i_wr_en && (i_wr_idx == IW'(k))) begin
                r_depth[k] <= i_wr_depth;
            end
        end
    end

    // One comparator per entry: entry depth above the query and inside the used span.
    for (genvar k = 0; k < NB; k++) begin : g_cmp
        if (k == 0) begin : g_origin
            assign hit[k] = (i_q < 0);
        end else if (k < MAX_POINTS) begin : g_entry
            assign hit[k] = (IW'(k) < i_n) && (r_depth[k] > i_q);
        end else begin : g_pad
            assign hit[k] = 1'b0;
        end
    end

    // Lowest hit within each group.
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_b_any[g] = |r_a_hit[g*plil_pkg::GRP_SIZE +: plil_pkg::GRP_SIZE];
            n_b_low[g] = '0;
            for (int j = plil_pkg::GRP_SIZE - 1; j >= 0; j--) begin
                if (r_a_hit[g*plil_pkg::GRP_SIZE + j]) begin
                    n_b_low[g] = plil_pkg::GRP_W'(j);
                end
            end
        end
    end

    // First hit over the groups, then step back one entry to the segment start.
    always_comb begin
        idx = r_b_n;
        for (int g = NG - 1; g >= 0; g--) begin
            if (r_b_any[g]) begin
                idx = IW'(g * plil_pkg::GRP_SIZE) + IW'(r_b_low[g]);
            end
        end
        n_c_seg = (idx == '0) ? '0 : idx - IW'(1);
    end

    // Stage registers; valid bits are cleared on reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_q_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_hit <= hit;
            r_a_q   <= i_q;
            r_a_n   <= i_n;
            r_b_any <= n_b_any;
            r_b_low <= n_b_low;
            r_b_q   <= r_a_q;
            r_b_n   <= r_a_n;
            r_c_seg <= n_c_seg;
            r_c_q   <= r_b_q;
        end
    end

    assign o_valid = r_c_valid;
    assign o_seg   = r_c_seg;
    assign o_q     = r_c_q;
    assign o_busy  = r_a_valid | r_b_valid | r_c_valid;

endmodule

// ===== rtl/plil_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module plil_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [plil_pkg::DATA_W-1:0]  i_num,
    input  logic [plil_pkg::DATA_W-1:0]  i_den,
    input  plil_pkg::t_side              i_side,
    output logic                         o_valid,
    output logic [plil_pkg::QUO_W-1:0]   o_quo,
    output plil_pkg::t_side              o_side
);

    localparam int QW = plil_pkg::QUO_W;
    localparam int DW = plil_pkg::DATA_W;

    logic                r_valid [QW];
    logic [DW-1:0]       r_rem   [QW];
    logic [QW-1:0]       r_nsh   [QW];
    logic [QW-1:0]       r_quo   [QW];
    logic [DW-1:0]       r_den   [QW];
    plil_pkg::t_side     r_side  [QW];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic            p_valid;
        logic [DW-1:0]   p_rem;
        logic [QW-1:0]   p_nsh;
        logic [QW-1:0]   p_quo;
        logic [DW-1:0]   p_den;
        plil_pkg::t_side p_side;
        logic [DW:0]     trial;
        logic            take;

        // The first stage starts from a zero remainder and the scaled offset.
        if (s == 0) begin : g_first
            assign p_valid = i_valid;
            assign p_rem   = '0;
            assign p_nsh   = {i_num, 16'b0};
            assign p_quo   = '0;
            assign p_den   = i_den;
            assign p_side  = i_side;
        end else begin : g_next
            assign p_valid = r_valid[s-1];
            assign p_rem   = r_rem[s-1];
            assign p_nsh   = r_nsh[s-1];
            assign p_quo   = r_quo[s-1];
            assign p_den   = r_den[s-1];
            assign p_side  = r_side[s-1];
        end

        // Bring down the next dividend bit and try the subtraction.
        assign trial = {p_rem, p_nsh[QW-1]};
        assign take  = (trial >= {1'b0, p_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_en) begin
                r_valid[s] <= p_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= take ? DW'(trial - {1'b0, p_den}) : DW'(trial);
                r_nsh[s]  <= {p_nsh[QW-2:0], 1'b0};
                r_quo[s]  <= {p_quo[QW-2:0], take};
                r_den[s]  <= p_den;
                r_side[s] <= p_side;
            end
        end
    end

    assign o_valid = r_valid[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

// ===== rtl/plil_mul.sv =====
// Segment fraction times time span in partial products, then offset, saturation and status.
module plil_mul (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [plil_pkg::QUO_W-1:0]          i_quo,
    input  plil_pkg::t_side                     i_side,
    output logic                                o_valid,
    output logic [plil_pkg::DATA_W-1:0]         o_time,
    output logic [1:0]                          o_status
);

    localparam int DW = plil_pkg::DATA_W;
    localparam int PW = DW + 16;
    localparam int FW = plil_pkg::QUO_W + DW;
    localparam int TW = FW - 16;

    logic            r_m1_valid;
    logic [PW-1:0]   r_p0;
    logic [PW-1:0]   r_p1;
    logic [PW-1:0]   r_p2;
    plil_pkg::t_side r_m1_side;

    logic [FW-1:0]   prod;
    logic            r_m2_valid;
    logic [TW-1:0]   r_term;
    plil_pkg::t_side r_m2_side;

    logic [DW+1:0]   ext_t0;
    logic [DW+1:0]   ext_term;
    logic [DW+1:0]   sum;
    logic            ovf;
    logic [DW-1:0]   sat_val;
    logic [DW-1:0]   n_time;
    logic [1:0]      n_status;

    logic            r_valid;
    logic [DW-1:0]   r_time;
    logic [1:0]      r_status;

    // Sum of the three shifted partial products; the fraction bits are dropped.
    assign prod = FW'(r_p0) + (FW'(r_p1) << 16) + (FW'(r_p2) << 32);

    // Signed offset and range check on a two-bit guard.
    assign ext_t0   = {{2{r_m2_side.t0[DW-1]}}, r_m2_side.t0};
    assign ext_term = {2'b00, r_term[DW-1:0]};
    assign sum      = r_m2_side.neg ? ext_t0 - ext_term : ext_t0 + ext_term;
    assign ovf      = (r_term[TW-1:DW] != '0) || (sum[DW+1:DW-1] != {3{sum[DW+1]}});
    assign sat_val  = r_m2_side.neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};

    always_comb begin
        if (r_m2_side.zero) begin
            n_time   = r_m2_side.t0;
            n_status = plil_pkg::ST_ZERO;
        end else if (ovf) begin
            n_time   = sat_val;
            n_status = plil_pkg::ST_SAT;
        end else begin
            n_time   = sum[DW-1:0];
            n_status = r_m2_side.extra ? plil_pkg::ST_EXTRA : plil_pkg::ST_INTERP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid <= 1'b0;
            r_m2_valid <= 1'b0;
            r_valid    <= 1'b0;
        end else if (i_en) begin
            r_m1_valid <= i_valid;
            r_m2_valid <= r_m1_valid;
            r_valid    <= r_m2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0      <= i_quo[15:0]  * i_side.adt;
            r_p1      <= i_quo[31:16] * i_side.adt;
            r_p2      <= i_quo[47:32] * i_side.adt;
            r_m1_side <= i_side;
            r_term    <= prod[FW-1:16];
            r_m2_side <= r_m1_side;
            r_time    <= n_time;
            r_status  <= n_status;
        end
    end

    assign o_valid  = r_valid;
    assign o_time   = r_time;
    assign o_status = r_status;

endmodule

// ===== rtl/piecewise_linear_interpolator_top.sv =====
// Piecewise linear interpolator: a depth query returns the time on its table segment.
// One query enters per cycle unless the output stalls; its result passes through the
// one-bit-per-stage quotient pipeline of 48 stages plus eight stages of search,
// table read, differences and multiply. Load beats return nothing; a load is held
// off while a query is still in the three search stages ahead of the table read.
// A stall on the output freezes the whole pipeline. Table entries above the origin
// that were never loaded read as undefined.
module piecewise_linear_interpolator_top #(
    parameter int MAX_POINTS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [plil_pkg::CFG_W-1:0]    i_cfg_wdata,   // points_used
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [71:0]                   s_axis_tdata,  // entry_index, depth_value, time_value
    input  logic                          s_axis_tuser,  // action
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [31:0]                   m_axis_tdata,  // time_out
    output logic [1:0]                    m_axis_tuser   // status
);

    localparam int IW = $clog2(MAX_POINTS + 1);
    localparam int DW = plil_pkg::DATA_W;

    logic [plil_pkg::CFG_W-1:0]  r_points;
    logic [IW-1:0]               n_eff;
    logic                        en;
    logic                        busy;
    logic                        accept;
    logic                        is_load;
    logic                        wr_ok;
    logic [IW-1:0]               wr_idx;
    logic [plil_pkg::IDX_W-1:0]  in_idx;
    logic signed [DW-1:0]        in_depth;
    logic signed [DW-1:0]        in_time;

    logic                        c_valid;
    logic [IW-1:0]               c_seg;
    logic signed [DW-1:0]        c_q;

    logic [DW-1:0]               rd_d0;
    logic [DW-1:0]               rd_d1;
    logic [DW-1:0]               rd_t0;
    logic [DW-1:0]               rd_t1;
    logic                        r_d_valid;
    logic signed [DW-1:0]        r_d_q;
    logic                        r_d_origin;

    logic signed [DW-1:0]        d0;
    logic signed [DW-1:0]        d1;
    logic signed [DW-1:0]        t0;
    logic signed [DW-1:0]        t1;
    logic [DW:0]                 dd;
    logic [DW:0]                 dw;
    logic [DW:0]                 dt;
    logic [DW:0]                 dd_mag;
    logic [DW:0]                 dw_mag;
    logic [DW:0]                 dt_mag;
    logic                        extra;
    plil_pkg::t_side             n_e_side;

    logic                        r_e_valid;
    logic [DW-1:0]               r_e_num;
    logic [DW-1:0]               r_e_den;
    plil_pkg::t_side             r_e_side;

    logic                        v_valid;
    logic [plil_pkg::QUO_W-1:0]  v_quo;
    plil_pkg::t_side             v_side;

    // Input beat fields.
    assign in_idx   = s_axis_tdata[6:0];
    assign in_depth = s_axis_tdata[38:7];
    assign in_time  = s_axis_tdata[70:39];
    assign is_load  = (s_axis_tuser == plil_pkg::ACT_LOAD);

    // The whole pipeline moves whenever the output register can take a beat.
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en && !(is_load && busy);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Loads to entry 0 or beyond the table are dropped.
    assign wr_ok  = accept && is_load && (in_idx != '0) && (int'(in_idx) <= MAX_POINTS);
    assign wr_idx = IW'(in_idx);

    // Points register, clamped into the table span.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points <= plil_pkg::CFG_W'(1);
        end else if (i_cfg_we) begin
            r_points <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (r_points == '0) begin
            n_eff = IW'(1);
        end else if (int'(r_points) > MAX_POINTS) begin
            n_eff = IW'(MAX_POINTS);
        end else begin
            n_eff = IW'(r_points);
        end
    end

    plil_search #(
        .MAX_POINTS (MAX_POINTS)
    ) u_search (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_wr_en    (wr_ok),
        .i_wr_idx   (wr_idx),
        .i_wr_depth (in_depth),
        .i_q_valid  (accept && !is_load),
        .i_q        (in_depth),
        .i_n        (n_eff),
        .o_valid    (c_valid),
        .o_seg      (c_seg),
        .o_q        (c_q),
        .o_busy     (busy)
    );

    // Segment end points come from the tables at seg and seg + 1.
    plil_ram #(
        .W     (DW),
        .DEPTH (MAX_POINTS + 1)
    ) u_depth_ram (
        .i_clk (i_clk),
        .i_we  (wr_ok),
        .i_wa  (wr_idx),
        .i_wd  (in_depth),
        .i_re  (en),
        .i_ra0 (c_seg),
        .i_ra1 (c_seg + IW'(1)),
        .o_rd0 (rd_d0),
        .o_rd1 (rd_d1)
    );

    plil_ram #(
        .W     (DW),
        .DEPTH (MAX_POINTS + 1)
    ) u_time_ram (
        .i_clk (i_clk),
        .i_we  (wr_ok),
        .i_wa  (wr_idx),
        .i_wd  (in_time),
        .i_re  (en),
        .i_ra0 (c_seg),
        .i_ra1 (c_seg + IW'(1)),
        .o_rd0 (rd_t0),
        .o_rd1 (rd_t1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else if (en) begin
            r_d_valid <= c_valid;
            r_e_valid <= r_d_valid;
        end
    end

    // The origin entry is fixed at zero.
    assign d0 = r_d_origin ? '0 : rd_d0;
    assign t0 = r_d_origin ? '0 : rd_t0;
    assign d1 = rd_d1;
    assign t1 = rd_t1;

    // Exact 33-bit differences and their magnitudes.
    assign dd     = {r_d_q[DW-1], r_d_q} - {d0[DW-1], d0};
    assign dw     = {d1[DW-1], d1} - {d0[DW-1], d0};
    assign dt     = {t1[DW-1], t1} - {t0[DW-1], t0};
    assign dd_mag = dd[DW] ? -dd : dd;
    assign dw_mag = dw[DW] ? -dw : dw;
    assign dt_mag = dt[DW] ? -dt : dt;

    // Outside the closed span of the segment means extrapolation.
    assign extra = (d0 <= d1) ? ((r_d_q < d0) || (r_d_q > d1))
                              : ((r_d_q < d1) || (r_d_q > d0));

    always_comb begin
        n_e_side.neg   = dd[DW] ^ dw[DW] ^ dt[DW];
        n_e_side.zero  = (dw == '0);
        n_e_side.extra = extra;
        n_e_side.adt   = dt_mag[DW-1:0];
        n_e_side.t0    = t0;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_q      <= c_q;
            r_d_origin <= (c_seg == '0);
            r_e_num    <= dd_mag[DW-1:0];
            r_e_den    <= dw_mag[DW-1:0];
            r_e_side   <= n_e_side;
        end
    end

    plil_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_e_valid),
        .i_num   (r_e_num),
        .i_den   (r_e_den),
        .i_side  (r_e_side),
        .o_valid (v_valid),
        .o_quo   (v_quo),
        .o_side  (v_side)
    );

    plil_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (v_valid),
        .i_quo    (v_quo),
        .i_side   (v_side),
        .o_valid  (m_axis_tvalid),
        .o_time   (m_axis_tdata),
        .o_status (m_axis_tuser)
    );

endmodule

// ===== rtl/plil_checker.sv =====
// Port-level checks for the interpolator, bound to the top level.
module plil_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // A result beat waiting on the consumer holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // A saturated result sits at one of the two limits.
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == plil_pkg::ST_SAT) |->
            (m_axis_tdata == 32'h7fff_ffff) || (m_axis_tdata == 32'h8000_0000))
        else $error("saturated result not at a limit");

endmodule

bind piecewise_linear_interpolator_top plil_checker u_plil_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/piecewise_linear_interpolator_top_test.sv =====
// Self-checking testbench for the piecewise linear interpolator top level.
`timescale 1ns / 100ps

module piecewise_linear_interpolator_top_test;

    localparam int NPTS      = 64;
    localparam int DRAIN_CYC = 64;    // drain wait that covers the pipeline latency with margin
    localparam int HOLD_CYC  = 400;   // long output stall that fills the pipeline
    localparam int WDOG_MAX  = 4000;  // cycles without any beat before giving up

    typedef struct {
        logic              act;
        logic [6:0]        idx;
        logic [31:0]       dep;
        logic [31:0]       tim;
        bit                typed;
        logic [31:0]       want_time;
        logic [1:0]        want_status;
    } t_row;

    typedef struct {
        logic [31:0] time_out;
        logic [1:0]  status;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [6:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // entry_index, depth_value, time_value
    logic        s_axis_tuser;   // action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // time_out
    logic [1:0]  m_axis_tuser;   // status

    // Predictor state: breakpoint tables and the points_used register.
    longint      depth_tab [0:NPTS];
    longint      time_tab  [0:NPTS];
    int unsigned pts_reg;

    t_answer     pending_times[$];
    t_row        dir_rows[$];
    int          n_errors;
    int          n_queries;
    int          n_loads;
    int          n_results;
    int          status_seen [4];
    int          send_idle;
    int          recv_idle;
    bit          hold_req;
    int          hold_left;
    int          quiet_cycles;

    piecewise_linear_interpolator_top #(.MAX_POINTS(NPTS)) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock generation.
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic longint unsigned abs_of(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // Computes the time at a query depth from the predictor's table.
    function automatic t_answer interp_time(logic signed [31:0] qd);
        longint q, n, i, d0, d1, t0, t1, dw, dd, dt, frac, m;
        longint unsigned af, adt, prod;
        bit neg, sat, extra;
        t_answer r;
        q = longint'(qd);
        sat = 1'b0;
        n = longint'(pts_reg);
        if (n < 1) n = 1;
        if (n > NPTS) n = NPTS;
        i = 0;
        while (i < n && !(depth_tab[i] > q)) i++;
        if (i > 0) i--;
        if (i > n - 1) i = n - 1;
        d0 = depth_tab[i];
        d1 = depth_tab[i + 1];
        t0 = time_tab[i];
        t1 = time_tab[i + 1];
        dw = d1 - d0;
        if (dw == 0) begin
            r.time_out = t0[31:0];
            r.status   = plil_pkg::ST_ZERO;
            return r;
        end
        dd   = q - d0;
        neg  = (dd < 0) != (dw < 0);
        af   = (abs_of(dd) << 16) / abs_of(dw);
        frac = neg ? -longint'(af) : longint'(af);
        dt   = t1 - t0;
        adt  = abs_of(dt);
        neg  = (frac < 0) != (dt < 0);
        if (adt != 0 && af > (64'd1 << 62) / adt) begin
            sat = 1'b1;
            m = neg ? -64'sd2147483648 : 64'sd2147483647;
        end else begin
            prod = af * adt;
            m = t0 + (neg ? -longint'(prod >> 16) : longint'(prod >> 16));
            if (m > 64'sd2147483647) begin
                m = 64'sd2147483647;
                sat = 1'b1;
            end
            if (m < -64'sd2147483648) begin
                m = -64'sd2147483648;
                sat = 1'b1;
            end
        end
        if (d0 <= d1) extra = (q < d0) || (q > d1);
        else          extra = (q < d1) || (q > d0);
        r.time_out = m[31:0];
        r.status   = sat ? plil_pkg::ST_SAT
                         : (extra ? plil_pkg::ST_EXTRA : plil_pkg::ST_INTERP);
        return r;
    endfunction

    function automatic t_row make_row(logic act, logic [6:0] idx, logic [31:0] dep,
                                      logic [31:0] tim, bit typed = 1'b0,
                                      logic [31:0] wt = '0,
                                      logic [1:0] ws = plil_pkg::ST_INTERP);
        t_row r;
        r.act = act;
        r.idx = idx;
        r.dep = dep;
        r.tim = tim;
        r.typed = typed;
        r.want_time = wt;
        r.want_status = ws;
        return r;
    endfunction

    // Offers one beat and records what the block must return once it is taken.
    task automatic send_beat(t_row r);
        t_answer a;
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, r.tim, r.dep, r.idx};
        s_axis_tuser  <= r.act;
        do @(posedge i_clk); while (!s_axis_tready);
        if (r.act == plil_pkg::ACT_QUERY) begin
            a = interp_time(r.dep);
            if (r.typed) begin
                a.time_out = r.want_time;
                a.status   = r.want_status;
            end
            pending_times.push_back(a);
            n_queries++;
        end else begin
            if (r.idx >= 1 && r.idx <= NPTS) begin
                depth_tab[r.idx] = longint'($signed(r.dep));
                time_tab[r.idx]  = longint'($signed(r.tim));
            end
            n_loads++;
        end
    endtask

    // Stops offering and waits until every result is back and the pipeline is empty.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending_times.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_points(logic [6:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        pts_reg = 32'(v);
    endtask

    // One random beat: mostly queries near loaded breakpoints, some loads, some noise.
    task automatic random_beat;
        int unsigned r, j, n;
        logic [6:0] idx;
        logic [31:0] dep, tim;
        r = $urandom_range(99);
        n = (pts_reg < 1) ? 1 : ((pts_reg > NPTS) ? NPTS : pts_reg);
        if (r < 12) begin
            idx = 7'($urandom_range(127));
            if (r < 6 && idx >= 1 && idx <= NPTS) begin
                dep = 32'(depth_tab[idx - 1] + $urandom_range(4096));
                tim = 32'(time_tab[idx - 1] + $urandom_range(8192) - 4096);
            end else begin
                dep = $urandom;
                tim = $urandom;
            end
            send_beat(make_row(plil_pkg::ACT_LOAD, idx, dep, tim));
        end else if (r < 80) begin
            j = $urandom_range(n);
            dep = 32'(depth_tab[j] + $urandom_range(4096) - 2048);
            send_beat(make_row(plil_pkg::ACT_QUERY, 7'($urandom_range(127)), dep, $urandom));
        end else begin
            send_beat(make_row(plil_pkg::ACT_QUERY, 7'($urandom_range(127)), $urandom,
                               $urandom));
        end
    endtask

    // Result side: random stalls, the long hold, and the compare against the oldest expectation.
    always @(posedge i_clk) begin
        t_answer e;
        if (m_axis_tvalid && m_axis_tready) begin
            if (pending_times.size() == 0) begin
                $error("result beat with nothing expected: time_out %h status %0d",
                       m_axis_tdata, m_axis_tuser);
                n_errors++;
            end else begin
                e = pending_times.pop_front();
                n_results++;
                status_seen[m_axis_tuser]++;
                if (m_axis_tdata !== e.time_out) begin
                    $error("time_out: expected %h, got %h", e.time_out, m_axis_tdata);
                    n_errors++;
                end
                if (m_axis_tuser !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, m_axis_tuser);
                    n_errors++;
                end
            end
        end
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYC;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Watchdog on cycles in which no beat moves on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WDOG_MAX) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Main sequence: reset, directed rows, then random phases over several settings.
    initial begin
        logic [6:0] cfg_list [7];
        int k;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = plil_pkg::ACT_LOAD;
        m_axis_tready = 1'b0;
        n_errors = 0;
        n_queries = 0;
        n_loads = 0;
        n_results = 0;
        quiet_cycles = 0;
        hold_req = 1'b0;
        hold_left = 0;
        send_idle = 6;
        recv_idle = 45;
        pts_reg = 1;
        for (k = 0; k < 4; k++) status_seen[k] = 0;
        for (k = 0; k <= NPTS; k++) begin
            depth_tab[k] = 0;
            time_tab[k]  = 0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows, with the reset value of points_used (one segment).
        dir_rows.push_back(make_row(plil_pkg::ACT_LOAD, 7'd1, 32'd256, 32'd512));
        dir_rows.push_back(make_row(plil_pkg::ACT_QUERY, 7'd0, 32'd0, 32'd0, 1, 32'd0,
                                    plil_pkg::ST_INTERP));
        dir_rows.push_back(make_row(plil_pkg::ACT_QUERY, 7'd0, 32'd256, 32'd0, 1, 32'd512,
                                    plil_pkg::ST_INTERP));
        dir_rows.push_back(make_row(plil_pkg::ACT_QUERY, 7'd0, 32'd128, 32'd0));
        dir_rows.push_back(make_row(plil_pkg::ACT_QUERY, 7'd0, -32'sd256, 32'd0, 1,
                                    -32'sd512, plil_pkg::ST_EXTRA));
        dir_rows.push_back(make_row(plil_pkg::ACT_QUERY, 7'd0, 32'd512, 32'd0, 1, 32'd1024,
                                    plil_pkg::ST_EXTRA));
        dir_rows.push_back(make_row(plil_pkg::ACT_QUERY, 7'd127, 32'h7fffffff, 32'hffffffff,
                                    1, 32'h7fffffff, plil_pkg::ST_SAT));
        dir_rows.push_back(make_row(plil_pkg::ACT_QUERY, 7'd0, 32'h80000000, 32'd0, 1,
                                    32'h80000000, plil_pkg::ST_SAT));
        // Loads to entry 0 or past the table end must leave the table alone.
        dir_rows.push_back(make_row(plil_pkg::ACT_LOAD, 7'd0, 32'd999, 32'd999));
        dir_rows.push_back(make_row(plil_pkg::ACT_LOAD, 7'd65, 32'd7, 32'd7));
        dir_rows.push_back(make_row(plil_pkg::ACT_LOAD, 7'd127, 32'hffffffff, 32'hffffffff));
        dir_rows.push_back(make_row(plil_pkg::ACT_QUERY, 7'd0, 32'd256, 32'd0, 1, 32'd512,
                                    plil_pkg::ST_INTERP));
        // Zero-width segment returns its start time.
        dir_rows.push_back(make_row(plil_pkg::ACT_LOAD, 7'd1, 32'd0, 32'd1000));
        dir_rows.push_back(make_row(plil_pkg::ACT_QUERY, 7'd0, 32'd12345, 32'd0, 1, 32'd0,
                                    plil_pkg::ST_ZERO));
        dir_rows.push_back(make_row(plil_pkg::ACT_QUERY, 7'd0, -32'sd5, 32'd0, 1, 32'd0,
                                    plil_pkg::ST_ZERO));
        // Extreme breakpoints, rising and falling.
        dir_rows.push_back(make_row(plil_pkg::ACT_LOAD, 7'd1, 32'h7fffffff, 32'h7fffffff));
        dir_rows.push_back(make_row(plil_pkg::ACT_QUERY, 7'd0, 32'h40000000, 32'd0));
        dir_rows.push_back(make_row(plil_pkg::ACT_QUERY, 7'd0, 32'h80000000, 32'd0));
        dir_rows.push_back(make_row(plil_pkg::ACT_LOAD, 7'd1, 32'h80000000, 32'h80000000));
        dir_rows.push_back(make_row(plil_pkg::ACT_QUERY, 7'd0, 32'h7fffffff, 32'd0));
        dir_rows.push_back(make_row(plil_pkg::ACT_QUERY, 7'd0, -32'sd100, 32'd0));
        // Query below every depth clamps to the first segment.
        dir_rows.push_back(make_row(plil_pkg::ACT_LOAD, 7'd1, -32'sd256, 32'd512));
        dir_rows.push_back(make_row(plil_pkg::ACT_QUERY, 7'd0, -32'sd1000, 32'd0));
        foreach (dir_rows[i]) send_beat(dir_rows[i]);

        // Fill the whole table with rising depths so any setting reads loaded entries.
        for (k = 1; k <= NPTS; k++)
            send_beat(make_row(plil_pkg::ACT_LOAD, k[6:0],
                               k * 32'd3000 + $urandom_range(1500) - 20000,
                               $urandom_range(65535) * 32'd64 - 32'd2000000));
        drain();

        // Random phases, each under its own setting of points_used.
        cfg_list = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd33, 7'd8, 7'd64};
        for (int p = 0; p < 7; p++) begin
            if (p == 2) begin
                send_idle = 45;
                recv_idle = 6;
            end else if (p == 5) begin
                send_idle = 0;
                recv_idle = 0;
                hold_req  = 1'b1;
            end
            write_points(cfg_list[p]);
            repeat (95) random_beat();
            drain();
        end

        $display("Covered %0d queries and %0d loads, %0d results checked.",
                 n_queries, n_loads, n_results);
        $display("Status counts: interp %0d, zero-width %0d, extrap %0d, saturated %0d.",
                 status_seen[plil_pkg::ST_INTERP], status_seen[plil_pkg::ST_ZERO],
                 status_seen[plil_pkg::ST_EXTRA], status_seen[plil_pkg::ST_SAT]);
        if (n_errors == 0 && pending_times.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== piecewise_linear_interpolator_top.f =====
rtl/plil_pkg.sv
rtl/plil_ram.sv
rtl/plil_search.sv
rtl/plil_div.sv
rtl/plil_mul.sv
rtl/piecewise_linear_interpolator_top.sv
rtl/plil_checker.sv
tb/piecewise_linear_interpolator_top_test.sv
